@@ hw/rtl/seom_pkg.sv @@
// ----------------------------------------------------------------------------
// seom_pkg: shared types and constants for the seed extension core
// Word formats of the pair and result channels, the scan state record and
// the character classification used by the extension step.
// ----------------------------------------------------------------------------
`default_nettype none

package seom_pkg;

  // Width of the running length counter; it saturates at its all-ones value.
  localparam int LENGTH_BITS = 20;
  // Width of the length and offset fields of a result word.
  localparam int FIELD_BITS = 20;

  localparam logic [1:0] STOP_END      = 2'd0;
  localparam logic [1:0] STOP_MISMATCH = 2'd1;
  localparam logic [1:0] STOP_NONNUC   = 2'd2;

  typedef struct packed {
    logic [7:0] base_first;
    logic [7:0] base_second;
    logic       start_req;
    logic       last;
    logic       allow_mismatch;
  } pair_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] match_length;
    logic [FIELD_BITS-1:0] mismatch_pos;
    logic [1:0]            stop_reason;
  } result_word_t;

  typedef struct packed {
    logic                   scanning;
    logic                   mismatch_seen;
    logic                   tolerate_one;
    logic [LENGTH_BITS-1:0] position;
    logic [LENGTH_BITS-1:0] first_mismatch_at;
  } scan_state_t;

  // True for A, C, G or T in either case.
  function automatic logic is_nucleotide(input logic [7:0] c);
    logic hit;
    unique case (c)
      "A", "C", "G", "T", "a", "c", "g", "t": hit = 1'b1;
      default:                                 hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/seed_extension_one_mismatch_core.sv @@
// ----------------------------------------------------------------------------
// seed_extension_one_mismatch_core: ungapped seed extension, one mismatch
// Streams character pairs from two sequences and reports how far they agree.
// Each pair word is captured in an input register and processed when the
// result register is free or being emptied; the scan state and the result
// register are updated at the same edge, so the core takes one pair per clock
// cycle while the result channel does not stall. A result stays in its
// register until the downstream side takes it. While it waits under a stall,
// the held pair is not processed, so the input register takes at most one
// more pair word and the pair channel then stalls until the result is taken.
// A pair with start_req set opens an extension (allow_mismatch is read only
// then); the scan stops at a first-sequence character other than A, C, G or
// T in either case, or at the mismatch beyond the tolerated one, and
// otherwise at the pair marked last. Pairs arriving while no extension is
// running are dropped without a result. The length counter holds at its
// maximum rather than wrapping.
// ----------------------------------------------------------------------------
`default_nettype none

module seed_extension_one_mismatch_core
  import seom_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Pair channel.
  input  logic         pair_valid,
  output logic         pair_stall,
  input  pair_word_t   pair,
  // Result channel.
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result
);

  // Input register: holds one pair word awaiting processing.
  logic        held_valid;
  pair_word_t  held;

  // Running scan state.
  scan_state_t state;
  scan_state_t state_next;

  logic         emit;
  result_word_t step_result;
  logic         advance;
  logic         take_pair;

  // The held word may be processed whenever the result register is free or
  // is being emptied in this cycle.
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign pair_stall = held_valid && !advance;
  assign take_pair  = pair_valid && !pair_stall;

  seom_step u_step (
    .state      (state),
    .pair       (held),
    .state_next (state_next),
    .emit       (emit),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take_pair) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pair) begin
      held <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= step_result;
    end
  end

`ifndef SYNTHESIS
  // The input side is only held back while a word is waiting in the register.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    pair_stall |-> held_valid)
    else $error("pair stalled with an empty input register");

  // A recorded mismatch offset can never lie beyond the reported length.
  a_offset_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.mismatch_pos <= result.match_length))
    else $error("mismatch offset beyond match length");

  // An extension that ends at the range end has counted at least one pair.
  a_end_counts_pair: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.stop_reason == STOP_END) |-> (result.match_length != '0))
    else $error("end-of-range result with zero length");

  // No mismatch recorded means no mismatch offset.
  a_offset_only_with_mismatch: assert property (@(posedge clk) disable iff (rst)
    !state.mismatch_seen |-> (state.first_mismatch_at == '0))
    else $error("mismatch offset set without a recorded mismatch");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/seom_step.sv @@
// ----------------------------------------------------------------------------
// seom_step: one step of the ungapped extension
// Combines the registered scan state with one pair word and gives the next
// state and, when the scan stops or the range ends, one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module seom_step
  import seom_pkg::*;
(
  input  scan_state_t  state,
  input  pair_word_t   pair,
  output scan_state_t  state_next,
  output logic         emit,
  output result_word_t result
);

  scan_state_t            cur;
  logic [LENGTH_BITS-1:0] pos_inc;
  logic                   differ;

  always_comb begin
    // A start request opens a fresh extension, dropping any running one.
    cur = state;
    if (pair.start_req) begin
      cur.scanning          = 1'b1;
      cur.mismatch_seen     = 1'b0;
      cur.tolerate_one      = pair.allow_mismatch;
      cur.position          = '0;
      cur.first_mismatch_at = '0;
    end

    differ  = (pair.base_first != pair.base_second);
    pos_inc = (&cur.position) ? cur.position : cur.position + 1'b1;

    state_next          = cur;
    emit                = 1'b0;
    result.match_length = FIELD_BITS'(cur.position);
    result.mismatch_pos = FIELD_BITS'(cur.first_mismatch_at);
    result.stop_reason  = STOP_END;

    if (cur.scanning) begin
      if (!is_nucleotide(pair.base_first)) begin
        emit                = 1'b1;
        result.stop_reason  = STOP_NONNUC;
        state_next.scanning = 1'b0;
      end else if (differ && (cur.mismatch_seen || !cur.tolerate_one)) begin
        emit                = 1'b1;
        result.stop_reason  = STOP_MISMATCH;
        state_next.scanning = 1'b0;
      end else begin
        if (differ) begin
          state_next.mismatch_seen     = 1'b1;
          state_next.first_mismatch_at = cur.position;
        end
        state_next.position = pos_inc;
        if (pair.last) begin
          emit                = 1'b1;
          result.match_length = FIELD_BITS'(pos_inc);
          if (differ) begin
            result.mismatch_pos = FIELD_BITS'(cur.position);
          end
          result.stop_reason  = STOP_END;
          state_next.scanning = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire
